[hw/rtl/tbru_pkg.sv]
// Package with command, status and memory request codes of the branch resolve unit.
`default_nettype none
package tbru_pkg;
    typedef enum logic [3:0] {
        CMD_B = 4'd0, CMD_BL = 4'd1, CMD_BX = 4'd2, CMD_BLX = 4'd3,
        CMD_CBZ = 4'd4, CMD_CBNZ = 4'd5, CMD_TBB = 4'd6, CMD_TBH = 4'd7,
        CMD_SG = 4'd8, CMD_BXNS = 4'd9, CMD_BLXNS = 4'd10, CMD_RESP = 4'd11
    } t_cmd;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_USG  = 3'd1;
    localparam logic [2:0] ST_BUS  = 3'd2;
    localparam logic [2:0] ST_SEC  = 3'd3;
    localparam logic [2:0] ST_UND  = 3'd4;
    localparam logic [2:0] ST_EXC  = 3'd5;
    localparam logic [2:0] ST_WAIT = 3'd6;

    localparam logic [2:0] MR_NONE = 3'd0;
    localparam logic [2:0] MR_RDB  = 3'd1;
    localparam logic [2:0] MR_RDH  = 3'd2;
    localparam logic [2:0] MR_RDW  = 3'd3;
    localparam logic [2:0] MR_WRW  = 3'd4;

    localparam logic [1:0] PK_NONE = 2'd0;
    localparam logic [1:0] PK_TBL  = 2'd1;
    localparam logic [1:0] PK_PUSH = 2'd2;
    localparam logic [1:0] PK_POP  = 2'd3;

    localparam logic [1:0] ATTR_S   = 2'd0;
    localparam logic [1:0] ATTR_NSC = 2'd2;

    localparam logic [31:0] FNC_RET_VAL  = 32'hFEFF_FFFF;
    localparam logic [31:0] EXC_RET_MASK = 32'hFF00_0000;

    localparam logic CFG_TZ    = 1'b0;
    localparam logic CFG_SPINI = 1'b1;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] pc;
        logic [31:0] rel;
        logic [31:0] ret;
        logic [31:0] reg_m;
        logic [31:0] reg_n;
        logic [1:0]  region_attr;
        logic [31:0] mem_data;
        logic        mem_fault;
        logic        is_exc;
        logic        is_fnc;
    } t_item;

    typedef struct packed {
        logic        pc_write;
        logic [31:0] new_pc;
        logic        lr_write;
        logic [31:0] lr_value;
        logic [2:0]  status;
        logic        clear_regs;
        logic [2:0]  mem_req;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic        secure_now;
        logic        invstate_set;
    } t_result;
endpackage
`default_nettype wire

[hw/rtl/tbru_front.sv]
// Front end: accept items, compute targets and classify, two-entry queue.
`default_nettype none
module tbru_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire [3:0]         i_cmd,
    input  wire [31:0]        i_pc,
    input  wire [24:0]        i_offset,
    input  wire [2:0]         i_insn_size,
    input  wire [31:0]        i_reg_m,
    input  wire [31:0]        i_reg_n,
    input  wire [1:0]         i_region_attr,
    input  wire [31:0]        i_mem_data,
    input  wire               i_mem_fault,
    output logic              o_valid,
    input  wire               i_ready,
    output tbru_pkg::t_item   o_item
);
    import tbru_pkg::*;

    t_item       r_q [2];
    logic [1:0]  r_cnt;
    logic        r_rd;
    logic        r_wr;
    t_item       n_item;
    logic        w_push;
    logic        w_pop;

    always_comb begin
        n_item.cmd         = i_cmd;
        n_item.pc          = i_pc;
        n_item.rel         = i_pc + 32'd4 + {{7{i_offset[24]}}, i_offset};
        n_item.ret         = (i_pc + {29'd0, i_insn_size}) | 32'd1;
        n_item.reg_m       = i_reg_m;
        n_item.reg_n       = i_reg_n;
        n_item.region_attr = i_region_attr;
        n_item.mem_data    = i_mem_data;
        n_item.mem_fault   = i_mem_fault;
        n_item.is_exc      = (i_reg_m & EXC_RET_MASK) == EXC_RET_MASK;
        n_item.is_fnc      = i_reg_m == FNC_RET_VAL;
    end

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_q[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_q[r_wr] <= n_item;
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_ready) |=> (r_cnt == 2'd2))
        else $error("full queue lost an entry");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_rd == r_wr))
        else $error("queue pointers out of step");
endmodule
`default_nettype wire

[hw/rtl/tbru_back.sv]
// Back end: execute branches against security state, output register.
`default_nettype none
module tbru_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire               i_cfg_idx,
    input  wire [31:0]        i_cfg_data,
    input  wire               i_valid,
    output logic              o_ready,
    input  tbru_pkg::t_item   i_item,
    output logic              o_valid,
    input  wire               i_ready,
    output tbru_pkg::t_result o_res
);
    import tbru_pkg::*;

    logic        r_tz;
    logic        r_sec;
    logic [31:0] r_sp;
    logic [1:0]  r_pk;
    logic [31:0] r_ppc;
    logic [31:0] r_ptgt;
    logic        r_ov;
    t_result     r_res;
    logic        n_sec;
    logic [31:0] n_sp;
    logic [1:0]  n_pk;
    logic [31:0] n_ppc;
    logic [31:0] n_ptgt;
    t_result     n_res;
    logic        w_go;
    logic [31:0] w_spm4;

    assign o_ready = !r_ov || i_ready;
    assign w_go    = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign w_spm4  = r_sp - 32'd4;

    always_comb begin
        n_sec  = r_sec;
        n_sp   = r_sp;
        n_pk   = r_pk;
        n_ppc  = r_ppc;
        n_ptgt = r_ptgt;
        n_res  = '0;
        if (i_item.cmd == CMD_RESP) begin
            n_pk = PK_NONE;
            case (r_pk)
                PK_TBL: begin
                    if (i_item.mem_fault) n_res.status = ST_BUS;
                    else begin
                        n_res.pc_write = 1'b1;
                        n_res.new_pc = (r_ppc + 32'd4 +
                            {(i_item.mem_data[30:0] & r_ptgt[30:0]), 1'b0}) & ~32'd1;
                    end
                end
                PK_PUSH: begin
                    if (i_item.mem_fault) begin
                        n_sp = r_sp + 32'd4;
                        n_res.status = ST_BUS;
                    end else begin
                        n_res.lr_write = 1'b1;
                        n_res.lr_value = FNC_RET_VAL;
                        n_res.clear_regs = 1'b1;
                        n_sec = 1'b0;
                        if (!r_ptgt[0]) n_res.status = ST_USG;
                        else begin
                            n_res.pc_write = 1'b1;
                            n_res.new_pc = r_ptgt & ~32'd1;
                        end
                    end
                end
                PK_POP: begin
                    if (i_item.mem_fault) n_res.status = ST_BUS;
                    else begin
                        n_sp = r_sp + 32'd4;
                        n_res.pc_write = 1'b1;
                        n_res.new_pc = i_item.mem_data & ~32'd1;
                    end
                end
                default: ;
            endcase
        end else if (r_pk != PK_NONE) begin
            n_res.status = ST_WAIT;
        end else begin
            unique case (i_item.cmd) inside
                CMD_B, CMD_BL: begin
                    if (i_item.cmd == CMD_BL) begin
                        n_res.lr_write = 1'b1;
                        n_res.lr_value = i_item.ret;
                    end
                    n_res.pc_write = 1'b1;
                    n_res.new_pc = i_item.rel & ~32'd1;
                end
                CMD_BX, CMD_BLX: begin
                    if (i_item.cmd == CMD_BLX) begin
                        n_res.lr_write = 1'b1;
                        n_res.lr_value = i_item.ret;
                    end
                    if (i_item.is_exc) begin
                        n_res.status = ST_EXC;
                        n_res.new_pc = i_item.reg_m;
                    end else if (i_item.cmd == CMD_BX && i_item.is_fnc && r_tz) begin
                        if (r_sec) begin
                            n_res.status = ST_USG;
                            n_res.invstate_set = 1'b1;
                        end else begin
                            n_sec = 1'b1;
                            n_pk = PK_POP;
                            n_res.status = ST_WAIT;
                            n_res.mem_req = MR_RDW;
                            n_res.mem_addr = r_sp;
                        end
                    end else if (!i_item.reg_m[0]) n_res.status = ST_USG;
                    else begin
                        n_res.pc_write = 1'b1;
                        n_res.new_pc = i_item.reg_m & ~32'd1;
                    end
                end
                CMD_CBZ, CMD_CBNZ: begin
                    if ((i_item.reg_n == 32'd0) == (i_item.cmd == CMD_CBZ)) begin
                        n_res.pc_write = 1'b1;
                        n_res.new_pc = i_item.rel & ~32'd1;
                    end
                end
                CMD_TBB, CMD_TBH: begin
                    n_pk = PK_TBL;
                    n_ppc = i_item.pc;
                    n_res.status = ST_WAIT;
                    if (i_item.cmd == CMD_TBB) begin
                        n_ptgt = 32'h0000_00FF;
                        n_res.mem_req = MR_RDB;
                        n_res.mem_addr = i_item.reg_n + i_item.reg_m;
                    end else begin
                        n_ptgt = 32'h0000_FFFF;
                        n_res.mem_req = MR_RDH;
                        n_res.mem_addr = i_item.reg_n + {i_item.reg_m[30:0], 1'b0};
                    end
                end
                CMD_SG, CMD_BXNS, CMD_BLXNS: begin
                    if (!r_tz) n_res.status = ST_UND;
                    else if (i_item.cmd == CMD_SG) begin
                        if (!r_sec) begin
                            if (i_item.region_attr != ATTR_NSC) n_res.status = ST_SEC;
                            else n_sec = 1'b1;
                        end
                    end else if (i_item.cmd == CMD_BXNS) begin
                        if (r_sec && i_item.region_attr == ATTR_S) n_res.status = ST_SEC;
                        else begin
                            if (r_sec) begin
                                n_res.clear_regs = 1'b1;
                                n_sec = 1'b0;
                            end
                            if (!i_item.reg_m[0]) n_res.status = ST_USG;
                            else begin
                                n_res.pc_write = 1'b1;
                                n_res.new_pc = i_item.reg_m & ~32'd1;
                            end
                        end
                    end else begin
                        n_res.lr_write = 1'b1;
                        n_res.lr_value = i_item.ret;
                        if (r_sec) begin
                            if (i_item.region_attr == ATTR_S) n_res.status = ST_SEC;
                            else begin
                                n_sp = w_spm4;
                                n_pk = PK_PUSH;
                                n_ptgt = i_item.reg_m;
                                n_res.status = ST_WAIT;
                                n_res.mem_req = MR_WRW;
                                n_res.mem_addr = w_spm4;
                                n_res.mem_wdata = i_item.ret;
                            end
                        end else if (!i_item.reg_m[0]) n_res.status = ST_USG;
                        else begin
                            n_res.pc_write = 1'b1;
                            n_res.new_pc = i_item.reg_m & ~32'd1;
                        end
                    end
                end
                default: n_res.status = ST_UND;
            endcase
        end
        n_res.secure_now = n_sec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz   <= 1'b1;
            r_sec  <= 1'b1;
            r_sp   <= 32'd0;
            r_pk   <= PK_NONE;
            r_ppc  <= 32'd0;
            r_ptgt <= 32'd0;
            r_ov   <= 1'b0;
        end else begin
            if (w_go) begin
                r_sec  <= n_sec;
                r_sp   <= n_sp;
                r_pk   <= n_pk;
                r_ppc  <= n_ppc;
                r_ptgt <= n_ptgt;
                r_ov   <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TZ) r_tz <= i_cfg_data[0];
                else r_sp <= i_cfg_data;
            end
        end
        if (w_go) r_res <= n_res;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(r_res)))
        else $error("stalled result changed");
    a_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && n_res.mem_req != MR_NONE) |=> (r_pk != PK_NONE))
        else $error("memory request without pending operation");
    a_sec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_res.secure_now == r_sec))
        else $error("secure_now out of step");
endmodule
`default_nettype wire

[hw/rtl/thumb_branch_resolve_unit.sv]
// Top level of the Thumb branch resolve unit.
// Path from input accept to result valid: queue entry, then output register.
// One item per cycle unless stalled; memory-assisted branches wait for a response item.
// Front queue holds two items, back end keeps one result in its output register.
// Synchronous active-low reset: secure state, empty pending, trustzone on, stack pointer 0.
`default_nettype none
module thumb_branch_resolve_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire [31:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[3:0] pc[35:4] offset[60:36] insn_size[63:61] reg_m[95:64] reg_n[127:96]
    // region_attr[129:128] mem_data[161:130] mem_fault[162]
    input  wire [167:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // pc_write[0] new_pc[32:1] lr_write[33] lr_value[65:34] status[68:66]
    // clear_regs[69] mem_req[72:70] mem_addr[104:73] mem_wdata[136:105]
    // secure_now[137] invstate_set[138]
    output logic [143:0] m_axis_tdata
);
    import tbru_pkg::*;

    t_item   w_item;
    t_result w_res;
    logic    w_qv;
    logic    w_qr;

    tbru_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cmd(s_axis_tdata[3:0]), .i_pc(s_axis_tdata[35:4]),
        .i_offset(s_axis_tdata[60:36]), .i_insn_size(s_axis_tdata[63:61]),
        .i_reg_m(s_axis_tdata[95:64]), .i_reg_n(s_axis_tdata[127:96]),
        .i_region_attr(s_axis_tdata[129:128]), .i_mem_data(s_axis_tdata[161:130]),
        .i_mem_fault(s_axis_tdata[162]),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_item)
    );

    tbru_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(w_qv), .o_ready(w_qr), .i_item(w_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {5'd0, w_res.invstate_set, w_res.secure_now, w_res.mem_wdata,
        w_res.mem_addr, w_res.mem_req, w_res.clear_regs, w_res.status,
        w_res.lr_value, w_res.lr_write, w_res.new_pc, w_res.pc_write};
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for the Thumb branch resolve unit: random and directed branches checked against a local predictor.
`timescale 1ns / 1ps
module tb_top;
    import tbru_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_idx = 1'b0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;

    thumb_branch_resolve_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    typedef struct {
        logic [3:0]  cmd;
        logic [31:0] pc;
        logic [24:0] offset;
        logic [2:0]  insn_size;
        logic [31:0] reg_m;
        logic [31:0] reg_n;
        logic [1:0]  region_attr;
        logic [31:0] mem_data;
        logic        mem_fault;
    } t_branch;

    t_branch     branch_q[$];
    logic [138:0] result_q[$];
    int          fail_cnt = 0;
    bit          calm = 1'b0;
    int          s_idle = 0;
    int          m_idle = 0;
    logic        s_fire;

    // predictor state
    logic        tz_on;
    logic        sec_st;
    logic [31:0] sec_sp;
    logic [1:0]  pend_kind;
    logic [31:0] pend_pc;
    logic [31:0] pend_tgt;

    function automatic t_result resolve_branch(t_branch b);
        t_result r;
        logic [31:0] rel, ret, d;
        r = '0;
        rel = b.pc + 32'd4 + {{7{b.offset[24]}}, b.offset};
        ret = (b.pc + {29'd0, b.insn_size}) | 32'd1;
        if (b.cmd == CMD_RESP) begin
            if (pend_kind == PK_TBL) begin
                if (b.mem_fault) r.status = ST_BUS;
                else begin
                    d = b.mem_data & pend_tgt;
                    r.pc_write = 1'b1;
                    r.new_pc = (pend_pc + 32'd4 + (d << 1)) & ~32'd1;
                end
            end else if (pend_kind == PK_PUSH) begin
                if (b.mem_fault) begin
                    sec_sp += 32'd4;
                    r.status = ST_BUS;
                end else begin
                    r.lr_write = 1'b1;
                    r.lr_value = FNC_RET_VAL;
                    r.clear_regs = 1'b1;
                    sec_st = 1'b0;
                    if (!pend_tgt[0]) r.status = ST_USG;
                    else begin
                        r.pc_write = 1'b1;
                        r.new_pc = pend_tgt & ~32'd1;
                    end
                end
            end else if (pend_kind == PK_POP) begin
                if (b.mem_fault) r.status = ST_BUS;
                else begin
                    sec_sp += 32'd4;
                    r.pc_write = 1'b1;
                    r.new_pc = b.mem_data & ~32'd1;
                end
            end
            pend_kind = PK_NONE;
        end else if (pend_kind != PK_NONE) begin
            r.status = ST_WAIT;
        end else if (b.cmd > CMD_RESP) begin
            r.status = ST_UND;
        end else begin
            case (t_cmd'(b.cmd)) inside
                CMD_B, CMD_BL: begin
                    if (b.cmd == CMD_BL) begin
                        r.lr_write = 1'b1;
                        r.lr_value = ret;
                    end
                    r.pc_write = 1'b1;
                    r.new_pc = rel & ~32'd1;
                end
                CMD_BX, CMD_BLX: begin
                    if (b.cmd == CMD_BLX) begin
                        r.lr_write = 1'b1;
                        r.lr_value = ret;
                    end
                    if ((b.reg_m & EXC_RET_MASK) == EXC_RET_MASK) begin
                        r.status = ST_EXC;
                        r.new_pc = b.reg_m;
                    end else if (b.cmd == CMD_BX && b.reg_m == FNC_RET_VAL && tz_on) begin
                        if (sec_st) begin
                            r.status = ST_USG;
                            r.invstate_set = 1'b1;
                        end else begin
                            sec_st = 1'b1;
                            pend_kind = PK_POP;
                            r.status = ST_WAIT;
                            r.mem_req = MR_RDW;
                            r.mem_addr = sec_sp;
                        end
                    end else if (!b.reg_m[0]) r.status = ST_USG;
                    else begin
                        r.pc_write = 1'b1;
                        r.new_pc = b.reg_m & ~32'd1;
                    end
                end
                CMD_CBZ, CMD_CBNZ: begin
                    if ((b.reg_n == 32'd0) == (b.cmd == CMD_CBZ)) begin
                        r.pc_write = 1'b1;
                        r.new_pc = rel & ~32'd1;
                    end
                end
                CMD_TBB, CMD_TBH: begin
                    pend_kind = PK_TBL;
                    pend_pc = b.pc;
                    pend_tgt = (b.cmd == CMD_TBB) ? 32'hFF : 32'hFFFF;
                    r.status = ST_WAIT;
                    r.mem_req = (b.cmd == CMD_TBB) ? MR_RDB : MR_RDH;
                    r.mem_addr = (b.cmd == CMD_TBB) ? b.reg_n + b.reg_m
                                                    : b.reg_n + (b.reg_m << 1);
                end
                default: begin
                    if (!tz_on) r.status = ST_UND;
                    else if (b.cmd == CMD_SG) begin
                        if (!sec_st) begin
                            if (b.region_attr != ATTR_NSC) r.status = ST_SEC;
                            else sec_st = 1'b1;
                        end
                    end else if (b.cmd == CMD_BXNS) begin
                        if (sec_st && b.region_attr == ATTR_S) r.status = ST_SEC;
                        else begin
                            if (sec_st) begin
                                r.clear_regs = 1'b1;
                                sec_st = 1'b0;
                            end
                            if (!b.reg_m[0]) r.status = ST_USG;
                            else begin
                                r.pc_write = 1'b1;
                                r.new_pc = b.reg_m & ~32'd1;
                            end
                        end
                    end else begin
                        r.lr_write = 1'b1;
                        r.lr_value = ret;
                        if (sec_st) begin
                            if (b.region_attr == ATTR_S) r.status = ST_SEC;
                            else begin
                                sec_sp -= 32'd4;
                                pend_kind = PK_PUSH;
                                pend_tgt = b.reg_m;
                                r.status = ST_WAIT;
                                r.mem_req = MR_WRW;
                                r.mem_addr = sec_sp;
                                r.mem_wdata = ret;
                            end
                        end else if (!b.reg_m[0]) r.status = ST_USG;
                        else begin
                            r.pc_write = 1'b1;
                            r.new_pc = b.reg_m & ~32'd1;
                        end
                    end
                end
            endcase
        end
        r.secure_now = sec_st;
        return r;
    endfunction

    function automatic logic [138:0] pack_result(t_result r);
        return {r.invstate_set, r.secure_now, r.mem_wdata, r.mem_addr, r.mem_req,
                r.clear_regs, r.status, r.lr_value, r.lr_write, r.new_pc, r.pc_write};
    endfunction

    function automatic t_branch rand_branch(logic [3:0] cmd);
        t_branch b;
        logic [31:0] hi;
        b.cmd = cmd;
        b.pc = $urandom;
        hi = $urandom;
        b.offset = hi[24:0];
        b.insn_size = $urandom_range(0, 3) == 0 ? 3'd2 : ($urandom_range(0, 1) ? 3'd4 : 3'd2);
        if ($urandom_range(0, 15) == 0) b.insn_size = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
            0: b.reg_m = FNC_RET_VAL;
            1: b.reg_m = 32'hFF00_0000 | $urandom;
            2: b.reg_m = $urandom_range(0, 255);
            default: b.reg_m = $urandom;
        endcase
        b.reg_n = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom;
        b.region_attr = 2'($urandom_range(0, 3));
        b.mem_data = $urandom;
        b.mem_fault = $urandom_range(0, 4) == 0;
        return b;
    endfunction

    // handshake acceptance happens at posedge; tvalid at negedge reflects that
    always @(posedge i_clk) s_fire <= s_axis_tvalid && s_axis_tready;

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_fire) begin
            if (s_idle > 0) begin
                s_idle <= s_idle - 1;
                s_axis_tvalid <= 1'b0;
            end else if (branch_q.size() > 0) begin
                t_branch b;
                b = branch_q.pop_front();
                result_q.push_back(pack_result(resolve_branch(b)));
                s_axis_tdata <= {5'd0, b.mem_fault, b.mem_data, b.region_attr, b.reg_n,
                                 b.reg_m, b.insn_size, b.offset, b.pc, b.cmd};
                s_axis_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) s_idle <= $urandom_range(1, 3);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (m_idle > 0) begin
            m_idle <= m_idle - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0) m_idle <= $urandom_range(1, 3);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            logic [138:0] want, got;
            got = m_axis_tdata[138:0];
            if (result_q.size() == 0) begin
                $error("result with nothing expected: %h", got);
                fail_cnt++;
            end else begin
                want = result_q.pop_front();
                if (got[0] !== want[0])
                    begin $error("pc_write exp %h got %h", want[0], got[0]); fail_cnt++; end
                if (got[32:1] !== want[32:1])
                    begin $error("new_pc exp %h got %h", want[32:1], got[32:1]); fail_cnt++; end
                if (got[33] !== want[33])
                    begin $error("lr_write exp %h got %h", want[33], got[33]); fail_cnt++; end
                if (got[65:34] !== want[65:34])
                    begin $error("lr_value exp %h got %h", want[65:34], got[65:34]); fail_cnt++; end
                if (got[68:66] !== want[68:66])
                    begin $error("status exp %h got %h", want[68:66], got[68:66]); fail_cnt++; end
                if (got[69] !== want[69])
                    begin $error("clear_regs exp %h got %h", want[69], got[69]); fail_cnt++; end
                if (got[72:70] !== want[72:70])
                    begin $error("mem_req exp %h got %h", want[72:70], got[72:70]); fail_cnt++; end
                if (got[104:73] !== want[104:73])
                    begin $error("mem_addr exp %h got %h", want[104:73], got[104:73]); fail_cnt++; end
                if (got[136:105] !== want[136:105])
                    begin $error("mem_wdata exp %h got %h", want[136:105], got[136:105]); fail_cnt++; end
                if (got[137] !== want[137])
                    begin $error("secure_now exp %h got %h", want[137], got[137]); fail_cnt++; end
                if (got[138] !== want[138])
                    begin $error("invstate_set exp %h got %h", want[138], got[138]); fail_cnt++; end
            end
        end
    end

    task automatic write_cfg(logic idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TZ) tz_on = val[0];
        else sec_sp = val;
    endtask

    task automatic drain_all();
        while (branch_q.size() > 0 || s_axis_tvalid || result_q.size() > 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // queue one sequence: instruction, sometimes a random extra item, then a response item
    task automatic push_seq(logic [3:0] cmd);
        t_branch b;
        b = rand_branch(cmd);
        branch_q.push_back(b);
        if ($urandom_range(0, 5) == 0) branch_q.push_back(rand_branch(4'($urandom_range(0, 15))));
        branch_q.push_back(rand_branch(CMD_RESP));
    endtask

    initial begin
        t_branch b;
        logic [3:0] c;
        tz_on = 1'b1; sec_st = 1'b1; sec_sp = '0;
        pend_kind = PK_NONE; pend_pc = '0; pend_tgt = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_cfg(CFG_SPINI, 32'h2000_1000);

        // directed
        b = rand_branch(CMD_B); b.offset = 25'h1000000; branch_q.push_back(b);
        b = rand_branch(CMD_BL); b.offset = 25'h0FFFFFE; b.pc = '1; branch_q.push_back(b);
        b = rand_branch(CMD_BX); b.reg_m = FNC_RET_VAL; branch_q.push_back(b);
        b = rand_branch(CMD_BLX); b.reg_m = 32'hFFFF_FFFD; branch_q.push_back(b);
        b = rand_branch(CMD_BX); b.reg_m = 32'h0000_1000; branch_q.push_back(b);
        b = rand_branch(CMD_CBZ); b.reg_n = '0; branch_q.push_back(b);
        b = rand_branch(CMD_CBNZ); b.reg_n = '0; branch_q.push_back(b);
        b = rand_branch(CMD_TBB); branch_q.push_back(b);
        b = rand_branch(CMD_B); branch_q.push_back(b);
        b = rand_branch(CMD_RESP); b.mem_fault = 1'b0; b.mem_data = '1; branch_q.push_back(b);
        b = rand_branch(CMD_TBH); branch_q.push_back(b);
        b = rand_branch(CMD_RESP); b.mem_fault = 1'b1; branch_q.push_back(b);
        b = rand_branch(CMD_RESP); branch_q.push_back(b);
        b = rand_branch(CMD_BLXNS); b.region_attr = 2'd1; b.reg_m = 32'h0000_2000;
        branch_q.push_back(b);
        b = rand_branch(CMD_RESP); b.mem_fault = 1'b0; branch_q.push_back(b);
        b = rand_branch(CMD_SG); b.region_attr = 2'd3; branch_q.push_back(b);
        b = rand_branch(CMD_BX); b.reg_m = FNC_RET_VAL; branch_q.push_back(b);
        b = rand_branch(CMD_RESP); b.mem_fault = 1'b0; branch_q.push_back(b);
        b = rand_branch(CMD_BXNS); b.region_attr = 2'd0; branch_q.push_back(b);
        b = rand_branch(CMD_BXNS); b.region_attr = 2'd1; b.reg_m = 32'h3; branch_q.push_back(b);
        b = rand_branch(CMD_SG); b.region_attr = 2'd2; branch_q.push_back(b);
        b = rand_branch(4'd15); branch_q.push_back(b);
        drain_all();

        for (int ph = 0; ph < 4; ph++) begin
            write_cfg(CFG_TZ, 32'(ph != 2));
            write_cfg(CFG_SPINI, ph == 1 ? 32'hFFFF_FFFF : (ph == 3 ? 32'd0 : $urandom));
            for (int n = 0; n < 300; n++) begin
                c = 4'($urandom_range(0, 15));
                if (c inside {CMD_TBB, CMD_TBH, CMD_BLXNS} || $urandom_range(0, 7) == 0)
                    push_seq(c);
                else branch_q.push_back(rand_branch(c));
                if (c == CMD_BX && $urandom_range(0, 1)) begin
                    b = rand_branch(CMD_BX); b.reg_m = FNC_RET_VAL; branch_q.push_back(b);
                    branch_q.push_back(rand_branch(CMD_RESP));
                end
            end
            if (ph == 3) calm = 1'b1;
            drain_all();
        end

        if (fail_cnt == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

[thumb_branch_resolve_unit.f]
hw/rtl/tbru_pkg.sv
hw/rtl/tbru_front.sv
hw/rtl/tbru_back.sv
hw/rtl/thumb_branch_resolve_unit.sv
tb/sv/tb_top.sv
